@@ src/tpd_pkg.sv @@
// ============================================================================
// tpd_pkg: shared types and constants of the true-peak detector
// Field widths, the queued item type and the 4x interpolation coefficients.
// ============================================================================
package tpd_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int TAP_COUNT    = 12;
    localparam int PHASE_COUNT  = 4;
    localparam int MAX_CHAN_DEF = 12;
    localparam int CH_W         = 4;
    localparam int PEAK_W       = 25;
    localparam int COEF_W       = 16;
    localparam int TAP_W        = $clog2(TAP_COUNT);
    localparam int PHASE_W      = $clog2(PHASE_COUNT);
    localparam int PROD_W       = SAMPLE_BITS + COEF_W;
    localparam int ACC_W        = PROD_W + TAP_W;
    localparam int MAG_SHIFT    = SAMPLE_BITS - 10;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [CH_W-1:0] NUM_CH_RESET = 4'd2;

    // Item as classified by the front end
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [CH_W-1:0]               channel;
        logic                          last;
        logic                          active;
        logic                          frame_end;
    } t_item;

    // Interpolation filter, Q2.14, one row per phase, newest sample on tap 0
    localparam logic signed [COEF_W-1:0] COEF_ROM [PHASE_COUNT][TAP_COUNT] = '{
        '{ 16'sd28,    16'sd180,  -16'sd322,   16'sd544,  -16'sd974,   16'sd2250,
           16'sd15928, -16'sd1676, 16'sd780,  -16'sd436,   16'sd244,  -16'sd136 },
        '{-16'sd478,   16'sd480,  -16'sd848,   16'sd1460, -16'sd2728,  16'sd7620,
           16'sd12776, -16'sd3282, 16'sd1664, -16'sd954,   16'sd542,  -16'sd310 },
        '{-16'sd310,   16'sd542,  -16'sd954,   16'sd1664, -16'sd3282,  16'sd12776,
           16'sd7620,  -16'sd2728, 16'sd1460, -16'sd848,   16'sd480,  -16'sd478 },
        '{-16'sd136,   16'sd244,  -16'sd436,   16'sd780,  -16'sd1676,  16'sd15928,
           16'sd2250,  -16'sd974,  16'sd544,  -16'sd322,   16'sd180,   16'sd28 }
    };

    function automatic logic signed [COEF_W-1:0] tap_coef(
        input logic [PHASE_W-1:0] phase,
        input logic [TAP_W-1:0]   tap
    );
        logic signed [COEF_W-1:0] c;
        c = '0;
        if (tap < TAP_W'(TAP_COUNT)) begin
            c = COEF_ROM[phase][tap];
        end
        return c;
    endfunction

    // Step a history position backwards with wrap
    function automatic logic [TAP_W-1:0] tap_dec(input logic [TAP_W-1:0] x);
        logic [TAP_W-1:0] r;
        r = (x == '0) ? TAP_W'(TAP_COUNT - 1) : x - 1'b1;
        return r;
    endfunction

endpackage

@@ src/true_peak_polyphase_detector.sv @@
// ============================================================================
// true_peak_polyphase_detector: 4x oversampled true-peak meter
// Polyphase interpolation per channel with a running block peak.
// ============================================================================
// Usage:
//   Input queue: drive sample, channel and last_of_block with push; the item
//   is taken on a clock edge with push high and full low. Channels arrive in
//   order 0 .. num_channels-1 within a frame.
//   Result queue: while empty is low, o_peak holds the oldest block peak; it
//   is taken on an edge with pop high. One result per item marked last.
//   Configuration: i_cfg_we writes the channel count; write it only idle.
// Timing:
//   An in-range sample occupies the MAC sequencer: taking it writes the
//   history RAM and runs tap 0, TAP issues one RAM read per remaining tap,
//   DRAIN empties the read pipe and PEAK folds the four phases into the
//   peak. A last marker adds EMIT, which waits while the result queue is
//   full; an out-of-range sample skips the MAC. Two-entry queues on both
//   sides let a stalled reader hold results while further samples are
//   still taken.
// Reset:
//   Clears both queues, the peak, the write position and the history valid
//   bits, so the whole history reads as zero; the channel count returns to 2.
// ============================================================================
module true_peak_polyphase_detector import tpd_pkg::*; #(
    parameter int MAX_CHAN = MAX_CHAN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CH_W-1:0]               i_cfg_wdata,
    input  logic                          push,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [CH_W-1:0]               i_channel,
    input  logic                          i_last_of_block,
    output logic                          full,
    output logic                          empty,
    input  logic                          pop,
    output logic [PEAK_W-1:0]             o_peak
);

    logic [CH_W-1:0] r_num_channels;
    t_item           item;
    logic            item_valid;
    logic            item_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_channels <= NUM_CH_RESET;
        end else if (i_cfg_we) begin
            r_num_channels <= i_cfg_wdata;
        end
    end

    tpd_front #(
        .MAX_CHAN (MAX_CHAN)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_num_channels  (r_num_channels),
        .i_push          (push),
        .i_sample        (i_sample),
        .i_channel       (i_channel),
        .i_last_of_block (i_last_of_block),
        .o_full          (full),
        .o_item          (item),
        .o_item_valid    (item_valid),
        .i_item_take     (item_take)
    );

    tpd_back #(
        .MAX_CHAN (MAX_CHAN)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_item_take  (item_take),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_peak       (o_peak)
    );

endmodule

@@ src/tpd_ram.sv @@
// ============================================================================
// tpd_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module tpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/tpd_fifo.sv @@
// ============================================================================
// tpd_fifo: small synchronous queue
// Register-based FIFO with full and empty flags, head shown while not empty.
// ============================================================================
module tpd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ src/tpd_front.sv @@
// ============================================================================
// tpd_front: input acceptance and classification
// Marks each sample as in range and as closing a frame, then queues it.
// ============================================================================
module tpd_front import tpd_pkg::*; #(
    parameter int MAX_CHAN = MAX_CHAN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [CH_W-1:0]               i_num_channels,
    input  logic                          i_push,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [CH_W-1:0]               i_channel,
    input  logic                          i_last_of_block,
    output logic                          o_full,
    output t_item                         o_item,
    output logic                          o_item_valid,
    input  logic                          i_item_take
);

    localparam int CNT_W = CH_W + 1;
    localparam int IW    = $bits(t_item);

    logic [CNT_W-1:0] eff_count;
    logic [CNT_W-1:0] ch_ext;
    t_item            in_item;
    logic [IW-1:0]    q_data;
    logic             q_empty;

    assign ch_ext    = {1'b0, i_channel};
    assign eff_count = ({1'b0, i_num_channels} < CNT_W'(MAX_CHAN))
                     ? {1'b0, i_num_channels} : CNT_W'(MAX_CHAN);

    always_comb begin
        in_item.sample    = i_sample;
        in_item.channel   = i_channel;
        in_item.last      = i_last_of_block;
        in_item.active    = (ch_ext < eff_count);
        // a zero count never marks a frame end since nothing is active
        in_item.frame_end = (ch_ext < eff_count) && (ch_ext == eff_count - 1'b1);
    end

    tpd_fifo #(
        .WIDTH (IW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (in_item),
        .o_full  (o_full),
        .i_pop   (i_item_take),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    assign o_item       = t_item'(q_data);
    assign o_item_valid = !q_empty;

endmodule

@@ src/tpd_back.sv @@
// ============================================================================
// tpd_back: history store, polyphase MAC sequencer and peak hold
// Writes the sample, steps four phase MACs over the taps, folds in the peak.
// ============================================================================
module tpd_back import tpd_pkg::*; #(
    parameter int MAX_CHAN = MAX_CHAN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_item             i_item,
    input  logic              i_item_valid,
    output logic              o_item_take,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [PEAK_W-1:0] o_peak
);

    localparam int DEPTH = MAX_CHAN * TAP_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int SH_W  = ACC_W - MAG_SHIFT;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_TAP   = 5'b00010,
        S_DRAIN = 5'b00100,
        S_PEAK  = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state                   r_state, n_state;
    t_item                    r_item;
    logic [TAP_W-1:0]         r_pos;
    logic [TAP_W-1:0]         r_idx;
    logic [TAP_W-1:0]         r_tap;
    logic                     r_rd_pend;
    logic [TAP_W-1:0]         r_rd_tap;
    logic                     r_hist_ok;
    logic [DEPTH-1:0]         r_valid;
    logic signed [ACC_W-1:0]  r_acc [PHASE_COUNT];
    logic signed [ACC_W-1:0]  n_acc [PHASE_COUNT];
    logic [PHASE_W-1:0]       r_phase;
    logic [PEAK_W-1:0]        r_peak;

    logic [AW-1:0]                 waddr;
    logic [AW-1:0]                 raddr;
    logic                          ram_we;
    logic [SAMPLE_BITS-1:0]        rdata;
    logic signed [SAMPLE_BITS-1:0] mac_sample;
    logic [TAP_W-1:0]              mac_tap;
    logic                          mac_en;
    logic                          mac_clear;
    logic signed [PROD_W-1:0]      prod [PHASE_COUNT];
    logic signed [ACC_W-1:0]       sel_acc;
    logic [ACC_W-1:0]              abs_acc;
    logic [SH_W-1:0]               shifted;
    logic [PEAK_W-1:0]             mag;
    logic                          out_full;
    logic                          out_push;

    assign o_item_take = (r_state == S_IDLE) && i_item_valid;
    assign ram_we      = o_item_take && i_item.active;
    assign waddr       = AW'(i_item.channel) * AW'(TAP_COUNT) + AW'(r_pos);
    assign raddr       = AW'(r_item.channel) * AW'(TAP_COUNT) + AW'(r_idx);
    assign out_push    = (r_state == S_EMIT) && !out_full;

    tpd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (i_item.sample),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Tap 0 is the incoming sample itself; later taps come back from the RAM
    always_comb begin
        mac_clear  = ram_we;
        mac_en     = ram_we || r_rd_pend;
        mac_sample = i_item.sample;
        mac_tap    = '0;
        if (!ram_we) begin
            mac_sample = r_hist_ok ? $signed(rdata) : '0;
            mac_tap    = r_rd_tap;
        end
        for (int p = 0; p < PHASE_COUNT; p++) begin
            prod[p]  = PROD_W'(mac_sample) * PROD_W'(tap_coef(PHASE_W'(p), mac_tap));
            n_acc[p] = mac_clear ? ACC_W'(prod[p]) : r_acc[p] + ACC_W'(prod[p]);
        end
    end

    // Magnitude of one phase, truncated to Q2.23 and saturated
    always_comb begin
        sel_acc = r_acc[r_phase];
        abs_acc = sel_acc[ACC_W-1] ? ACC_W'(-sel_acc) : ACC_W'(sel_acc);
        shifted = SH_W'(abs_acc >> MAG_SHIFT);
        mag     = (|shifted[SH_W-1:PEAK_W]) ? '1 : shifted[PEAK_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    if (i_item.active) begin
                        n_state = S_TAP;
                    end else if (i_item.last) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_TAP: begin
                if (r_tap == TAP_W'(TAP_COUNT - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_PEAK;
            S_PEAK: begin
                if (r_phase == PHASE_W'(PHASE_COUNT - 1)) begin
                    n_state = r_item.last ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (!out_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_valid   <= '0;
            r_peak    <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= (r_state == S_TAP);
            if (ram_we) begin
                r_valid[waddr] <= 1'b1;
            end
            if (r_state == S_PEAK) begin
                if (mag > r_peak) begin
                    r_peak <= mag;
                end
                // advance the shared position once the frame's last channel is done
                if (r_phase == PHASE_W'(PHASE_COUNT - 1) && r_item.frame_end) begin
                    r_pos <= (r_pos == TAP_W'(TAP_COUNT - 1)) ? '0 : r_pos + 1'b1;
                end
            end
            if (out_push) begin
                r_peak <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_take) begin
            r_item <= i_item;
            r_idx  <= tap_dec(r_pos);
            r_tap  <= TAP_W'(1);
        end
        if (r_state == S_TAP) begin
            r_idx     <= tap_dec(r_idx);
            r_tap     <= r_tap + 1'b1;
            r_hist_ok <= r_valid[raddr];
        end
        r_rd_tap <= r_tap;
        if (mac_en) begin
            for (int p = 0; p < PHASE_COUNT; p++) begin
                r_acc[p] <= n_acc[p];
            end
        end
        if (r_state == S_DRAIN) begin
            r_phase <= '0;
        end else if (r_state == S_PEAK) begin
            r_phase <= r_phase + 1'b1;
        end
    end

    tpd_fifo #(
        .WIDTH (PEAK_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (r_peak),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_data  (o_peak),
        .o_empty (o_empty)
    );

endmodule

@@ src/tpd_checker.sv @@
// ============================================================================
// tpd_checker: port-level checks for the true-peak detector
// Reset behaviour of both queues and stability of a waiting result.
// ============================================================================
module tpd_checker import tpd_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input logic [PEAK_W-1:0] o_peak
);

    // after reset no result reaches the output before an item has passed the input queue and the sequencer
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n, 2) |-> empty)
        else $error("result shown too soon after reset");

    a_reset_not_full: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !full)
        else $error("input queue full after reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty)
        else $error("waiting result withdrawn");

    a_result_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> $stable(o_peak))
        else $error("waiting result changed");

endmodule

bind true_peak_polyphase_detector tpd_checker u_tpd_checker (.*);

@@ dv/tb_top.sv @@
// ============================================================================
// tb_top: self-checking bench for the true-peak polyphase detector
// Drives interleaved audio samples through the input queue under varying
// channel counts and idle patterns, predicts every block peak with an
// independent 4x polyphase interpolator, and compares each popped peak.
// ============================================================================
module tb_top import tpd_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST_TAPS      = 12;
    localparam int HIST_CHANNELS  = 12;
    localparam int PHASES         = 4;
    localparam int FRAC_DROP      = 14;
    localparam longint PEAK_MAX   = 64'h1FF_FFFF;
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES     = 9;

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 24'sh800000;

    // 4x interpolation filter, Q2.14, newest sample on tap 0
    localparam int INTERP_COEF [PHASES][HIST_TAPS] = '{
        '{   28,   180,  -322,   544,  -974,  2250, 15928, -1676,   780,  -436,   244,  -136 },
        '{ -478,   480,  -848,  1460, -2728,  7620, 12776, -3282,  1664,  -954,   542,  -310 },
        '{ -310,   542,  -954,  1664, -3282, 12776,  7620, -2728,  1460,  -848,   480,  -478 },
        '{ -136,   244,  -436,   780, -1676, 15928,  2250,  -974,   544,  -322,   180,    28 }
    };

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [CH_W-1:0]               channel;
        logic                          last;
        logic                          has_lit;
        logic [PEAK_W-1:0]             lit_peak;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 22;
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        '{24'sd0,         4'd0,  1'b1, 1'b1, 25'd0},       // peak is zero after reset
        '{S_MIN,          4'd0,  1'b1, 1'b1, 25'd244736},  // full-scale negative on tap 0
        '{S_MAX,          4'd1,  1'b1, 1'b1, 25'd244735},  // full-scale positive, frame end
        '{24'sd0,         4'd2,  1'b1, 1'b1, 25'd0},       // marker on an ignored sample
        '{24'sh123456,    4'd15, 1'b0, 1'b0, 25'd0},
        '{S_MAX,          4'd0,  1'b0, 1'b0, 25'd0},
        '{S_MIN,          4'd1,  1'b0, 1'b0, 25'd0},
        '{S_MIN,          4'd0,  1'b0, 1'b0, 25'd0},
        '{S_MAX,          4'd1,  1'b0, 1'b0, 25'd0},
        '{S_MAX,          4'd0,  1'b0, 1'b0, 25'd0},
        '{S_MIN,          4'd1,  1'b0, 1'b0, 25'd0},
        '{S_MIN,          4'd0,  1'b0, 1'b0, 25'd0},
        '{S_MAX,          4'd1,  1'b0, 1'b0, 25'd0},
        '{S_MAX,          4'd0,  1'b0, 1'b0, 25'd0},
        '{S_MIN,          4'd1,  1'b0, 1'b0, 25'd0},
        '{S_MIN,          4'd0,  1'b0, 1'b0, 25'd0},
        '{S_MAX,          4'd1,  1'b1, 1'b0, 25'd0},
        '{24'sh555555,    4'd0,  1'b0, 1'b0, 25'd0},
        '{24'shAAAAAA,    4'd1,  1'b1, 1'b0, 25'd0},
        '{-24'sd1,        4'd0,  1'b0, 1'b0, 25'd0},
        '{24'sd1,         4'd1,  1'b0, 1'b0, 25'd0},
        '{24'sd0,         4'd3,  1'b1, 1'b0, 25'd0}
    };

    localparam int PHASE_CFG [NUM_PHASES] = '{12, 1, 15, 0, 7, 2, 5, 12, 3};

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [CH_W-1:0]               i_cfg_wdata = '0;
    logic                          push = 1'b0;
    logic signed [SAMPLE_BITS-1:0] i_sample = '0;
    logic [CH_W-1:0]               i_channel = '0;
    logic                          i_last_of_block = 1'b0;
    logic                          pop = 1'b0;
    logic                          full;
    logic                          empty;
    logic [PEAK_W-1:0]             o_peak;

    // Predictor state
    logic signed [SAMPLE_BITS-1:0] hist [HIST_CHANNELS][HIST_TAPS];
    int                            write_pos;
    logic [PEAK_W-1:0]             block_peak;
    logic [CH_W-1:0]               chan_count;

    logic [PEAK_W-1:0] expected_peaks [$];
    int send_idle_pct = 20;
    int recv_idle_pct = 78;
    int fail_count = 0;
    int samples_taken = 0;
    int peaks_checked = 0;
    int quiet_cycles = 0;

    true_peak_polyphase_detector dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .push            (push),
        .i_sample        (i_sample),
        .i_channel       (i_channel),
        .i_last_of_block (i_last_of_block),
        .full            (full),
        .empty           (empty),
        .pop             (pop),
        .o_peak          (o_peak)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // For an in-range channel, write the sample into its history, run the four
    // phases and fold them into the block peak; returns 1 when a peak is emitted.
    function automatic bit track_sample(
        input  logic signed [SAMPLE_BITS-1:0] s,
        input  logic [CH_W-1:0]               ch,
        input  logic                          last,
        output logic [PEAK_W-1:0]             peak_out
    );
        int     eff;
        int     idx;
        longint acc;
        longint mag;
        eff = (chan_count < HIST_CHANNELS) ? int'(chan_count) : HIST_CHANNELS;
        peak_out = '0;
        if (int'(ch) < eff) begin
            samples_taken++;
            hist[ch][write_pos] = s;
            for (int p = 0; p < PHASES; p++) begin
                acc = 0;
                for (int t = 0; t < HIST_TAPS; t++) begin
                    idx = (write_pos + HIST_TAPS - t) % HIST_TAPS;
                    acc += longint'(INTERP_COEF[p][t]) * longint'(hist[ch][idx]);
                end
                mag = (acc < 0) ? -acc : acc;
                mag = mag >> FRAC_DROP;
                if (mag > PEAK_MAX) mag = PEAK_MAX;
                if (mag > longint'(block_peak)) block_peak = PEAK_W'(mag);
            end
            if (int'(ch) == eff - 1) write_pos = (write_pos + 1) % HIST_TAPS;
        end
        if (last) begin
            peak_out = block_peak;
            block_peak = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        logic signed [SAMPLE_BITS-1:0] s;
        case ($urandom_range(0, 9))
            0: s = S_MAX;
            1: s = S_MIN;
            2: s = '0;
            3: s = SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
            default: s = SAMPLE_BITS'($urandom);
        endcase
        return s;
    endfunction

    // Offer one sample, hold it until the transaction completes, then predict
    task automatic send_item(
        input logic signed [SAMPLE_BITS-1:0] s,
        input logic [CH_W-1:0]               ch,
        input logic                          last,
        input logic                          has_lit,
        input logic [PEAK_W-1:0]             lit_peak
    );
        logic [PEAK_W-1:0] predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push            <= 1'b1;
        i_sample        <= s;
        i_channel       <= ch;
        i_last_of_block <= last;
        do @(posedge i_clk); while (full);
        if (track_sample(s, ch, last, predicted))
            expected_peaks.push_back(has_lit ? lit_peak : predicted);
    endtask

    // Change the channel count only once the block has gone quiet
    task automatic write_channel_count(input int value);
        push <= 1'b0;
        while (expected_peaks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CH_W'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        chan_count = CH_W'(value);
    endtask

    task automatic run_random_phase(input int cfg, input int target);
        int eff;
        int taken;
        int stop;
        int n;
        logic [CH_W-1:0] ch;
        eff = (cfg < HIST_CHANNELS) ? cfg : HIST_CHANNELS;
        taken = 0;
        write_channel_count(cfg);
        if (eff == 0) begin
            repeat (30)
                send_item(random_sample(), CH_W'($urandom_range(0, 15)),
                          $urandom_range(0, 3) == 0, 1'b0, '0);
        end else begin
            while (taken < target) begin
                if ($urandom_range(0, 99) < 85) begin
                    // well-formed block of whole frames, now and then cut short
                    n = $urandom_range(1, 4) * eff;
                    stop = n - 1;
                    if ($urandom_range(0, 6) == 0) stop = n - eff + $urandom_range(0, eff - 1);
                    for (int k = 0; k <= stop; k++)
                        send_item(random_sample(), CH_W'(k % eff), k == stop, 1'b0, '0);
                    taken += stop + 1;
                end else begin
                    n = $urandom_range(1, 6);
                    repeat (n) begin
                        ch = CH_W'($urandom_range(0, 15));
                        send_item(random_sample(), ch, $urandom_range(0, 3) == 0, 1'b0, '0);
                        if (int'(ch) < eff) taken++;
                    end
                end
            end
        end
    endtask

    // Result side: check each popped peak, then decide whether to stall
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (expected_peaks.size() == 0) begin
                $error("peak: no result expected, actual %0d", o_peak);
                fail_count++;
            end else begin
                peaks_checked++;
                if (o_peak !== expected_peaks[0]) begin
                    $error("peak: expected %0d, actual %0d", expected_peaks[0], o_peak);
                    fail_count++;
                end
                void'(expected_peaks.pop_front());
            end
        end
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int c = 0; c < HIST_CHANNELS; c++)
            for (int t = 0; t < HIST_TAPS; t++)
                hist[c][t] = '0;
        write_pos  = 0;
        block_peak = '0;
        chan_count = NUM_CH_RESET;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_item(DIRECTED[r].sample, DIRECTED[r].channel, DIRECTED[r].last,
                      DIRECTED[r].has_lit, DIRECTED[r].lit_peak);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph / 3)
                0: begin send_idle_pct = 20; recv_idle_pct = 78; end
                1: begin send_idle_pct = 78; recv_idle_pct = 20; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            run_random_phase(PHASE_CFG[ph], 145);
        end

        // drain
        push <= 1'b0;
        while (expected_peaks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d in-range samples and %0d block peaks,", samples_taken,
                 peaks_checked);
        $display("channel counts from 0 to 15 under three idle patterns.");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
